@@ hdl/sprite_blit_color_key_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sprite blitter assertion macros
// Shared concurrent check wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BLIT_COLOR_KEY_TOP_DEFINES_SVH
`define SPRITE_BLIT_COLOR_KEY_TOP_DEFINES_SVH

// same-cycle implication
`define SBCK_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbck same-cycle check failed");

// next-cycle implication
`define SBCK_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbck next-cycle check failed");

`endif

@@ hdl/sbck_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter package
// Screen size, field widths, register map and result item type.
// ----------------------------------------------------------------------------
package sbck_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 8;
    localparam int ORIGIN_W = 10;
    localparam int COLOUR_W = 16;
    localparam int COORD_W  = 12;   // signed placement math

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    typedef enum logic [2:0] {
        REG_SPRITE_WIDTH  = 3'd0,
        REG_SPRITE_HEIGHT = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_KEY_ENABLE    = 3'd4,
        REG_KEY_COLOUR    = 3'd5,
        REG_MIRROR        = 3'd6,
        REG_TARGET_BUFFER = 3'd7
    } t_reg_idx;

    typedef enum logic {
        ACT_WRITE   = 1'b0,
        ACT_RESTORE = 1'b1
    } t_action;

    typedef struct packed {
        t_action             action;
        logic                buffer_select;
        logic [COLOUR_W-1:0] out_colour;
        logic [HEIGHT_W-1:0] screen_y;
        logic [WIDTH_W-1:0]  screen_x;
    } t_result;

endpackage

@@ hdl/sprite_blit_color_key_top.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter with color-key transparency
// Places a raster stream of RGB565 sprite pixels on a 320x240 screen.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sprite pixel per item, rows in stored order (the first
//   stored row is the bottom screen row). m_axis carries at most one command
//   per pixel: tuser 0 writes tdata colour, tuser 1 restores background.
//   Off-screen pixels produce nothing but still advance the row/column
//   counters. Registers are written over the APB port while the stream idles.
// Timing:
//   One pixel accepted per clock while the skid entry is free. A command is
//   registered after its pixel is accepted. Placement, clipping and key match
//   are one add/compare pass into the output register or the skid entry.
// Reset:
//   Counters clear to the sprite's first pixel, width and height go to 1,
//   other registers to 0, output is empty.
// Stall:
//   A two-entry output (register plus skid) keeps accepting while a result
//   waits; s_axis_tready drops only while the skid entry is occupied.
// ----------------------------------------------------------------------------
`include "sprite_blit_color_key_top_defines.svh"

module sprite_blit_color_key_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB config
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbck_pkg::PADDR_W-1:0]       paddr,
    input  logic [sbck_pkg::PDATA_W-1:0]       pwdata,
    output logic [sbck_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // pixel in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sbck_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] pixel_colour
    // command out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [8:0] screen_x, [16:9] screen_y, [32:17] out_colour, [33] buffer_select,
    // [39:34] zero
    output logic [sbck_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tuser   // [0] action
);

    localparam int CW = sbck_pkg::COORD_W;

    // config registers
    logic [sbck_pkg::WIDTH_W-1:0]  r_sprite_width;
    logic [sbck_pkg::HEIGHT_W-1:0] r_sprite_height;
    logic [sbck_pkg::ORIGIN_W-1:0] r_origin_x;
    logic [sbck_pkg::ORIGIN_W-1:0] r_origin_y;
    logic                          r_key_enable;
    logic [sbck_pkg::COLOUR_W-1:0] r_key_colour;
    logic                          r_mirror;
    logic                          r_target_buffer;

    // raster counters
    logic [sbck_pkg::WIDTH_W-1:0]  r_col;
    logic [sbck_pkg::HEIGHT_W-1:0] r_row;
    logic [sbck_pkg::WIDTH_W-1:0]  n_col;
    logic [sbck_pkg::HEIGHT_W-1:0] n_row;

    // output register and skid
    sbck_pkg::t_result r_out;
    sbck_pkg::t_result r_skid;
    logic              r_out_vld;
    logic              r_skid_vld;
    sbck_pkg::t_result n_out;
    sbck_pkg::t_result n_skid;
    logic              n_out_vld;
    logic              n_skid_vld;

    logic                 cfg_wr;
    sbck_pkg::t_reg_idx   cfg_idx;
    logic                 s_acc;
    logic                 m_acc;
    logic signed [CW-1:0] ox, oy, col_s, row_s, w_s, h_s, px, py;
    logic                 on_screen;
    logic                 keyed;
    logic                 hit;
    logic [sbck_pkg::COLOUR_W-1:0] pix;
    logic [sbck_pkg::WIDTH_W:0]    col_p1;
    logic [sbck_pkg::HEIGHT_W:0]   row_p1;
    sbck_pkg::t_result    res;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = sbck_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_width  <= sbck_pkg::WIDTH_W'(1);
            r_sprite_height <= sbck_pkg::HEIGHT_W'(1);
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_key_enable    <= 1'b0;
            r_key_colour    <= '0;
            r_mirror        <= 1'b0;
            r_target_buffer <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sbck_pkg::REG_SPRITE_WIDTH:  r_sprite_width  <= pwdata[8:0];
                sbck_pkg::REG_SPRITE_HEIGHT: r_sprite_height <= pwdata[7:0];
                sbck_pkg::REG_ORIGIN_X:      r_origin_x      <= pwdata[9:0];
                sbck_pkg::REG_ORIGIN_Y:      r_origin_y      <= pwdata[9:0];
                sbck_pkg::REG_KEY_ENABLE:    r_key_enable    <= pwdata[0];
                sbck_pkg::REG_KEY_COLOUR:    r_key_colour    <= pwdata[15:0];
                sbck_pkg::REG_MIRROR:        r_mirror        <= pwdata[0];
                sbck_pkg::REG_TARGET_BUFFER: r_target_buffer <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            sbck_pkg::REG_SPRITE_WIDTH:  prdata = {23'd0, r_sprite_width};
            sbck_pkg::REG_SPRITE_HEIGHT: prdata = {24'd0, r_sprite_height};
            sbck_pkg::REG_ORIGIN_X:      prdata = {22'd0, r_origin_x};
            sbck_pkg::REG_ORIGIN_Y:      prdata = {22'd0, r_origin_y};
            sbck_pkg::REG_KEY_ENABLE:    prdata = {31'd0, r_key_enable};
            sbck_pkg::REG_KEY_COLOUR:    prdata = {16'd0, r_key_colour};
            sbck_pkg::REG_MIRROR:        prdata = {31'd0, r_mirror};
            sbck_pkg::REG_TARGET_BUFFER: prdata = {31'd0, r_target_buffer};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- placement ----------------
    assign s_axis_tready = !r_skid_vld;
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign m_acc         = r_out_vld & m_axis_tready;
    assign pix           = s_axis_tdata[15:0];

    assign ox    = {{(CW-sbck_pkg::ORIGIN_W){r_origin_x[9]}}, r_origin_x};
    assign oy    = {{(CW-sbck_pkg::ORIGIN_W){r_origin_y[9]}}, r_origin_y};
    assign col_s = {{(CW-sbck_pkg::WIDTH_W){1'b0}}, r_col};
    assign row_s = {{(CW-sbck_pkg::HEIGHT_W){1'b0}}, r_row};
    assign w_s   = {{(CW-sbck_pkg::WIDTH_W){1'b0}}, r_sprite_width};
    assign h_s   = {{(CW-sbck_pkg::HEIGHT_W){1'b0}}, r_sprite_height};

    assign px = r_mirror ? (ox + w_s - CW'(1) - col_s) : (ox + col_s);
    assign py = oy + h_s - CW'(1) - row_s;

    assign on_screen = !px[CW-1] && (px < CW'(sbck_pkg::SCREEN_WIDTH))
                    && !py[CW-1] && (py < CW'(sbck_pkg::SCREEN_HEIGHT));
    assign keyed     = r_key_enable && (pix == r_key_colour);
    assign hit       = s_acc && on_screen;

    always_comb begin
        res.action        = keyed ? sbck_pkg::ACT_RESTORE : sbck_pkg::ACT_WRITE;
        res.screen_x      = px[sbck_pkg::WIDTH_W-1:0];
        res.screen_y      = py[sbck_pkg::HEIGHT_W-1:0];
        res.out_colour    = keyed ? '0 : pix;
        res.buffer_select = keyed ? 1'b0 : r_target_buffer;
    end

    // ---------------- raster counters ----------------
    assign col_p1 = {1'b0, r_col} + (sbck_pkg::WIDTH_W+1)'(1);
    assign row_p1 = {1'b0, r_row} + (sbck_pkg::HEIGHT_W+1)'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_acc) begin
            if (col_p1 >= {1'b0, r_sprite_width}) begin
                n_col = '0;
                n_row = (row_p1 >= {1'b0, r_sprite_height}) ? '0
                                                             : row_p1[sbck_pkg::HEIGHT_W-1:0];
            end else begin
                n_col = col_p1[sbck_pkg::WIDTH_W-1:0];
            end
        end
    end

    // ---------------- output and skid ----------------
    always_comb begin
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (m_acc || !r_out_vld) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = res;
                n_out_vld = hit;
            end
        end else if (hit) begin
            n_skid     = res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {6'd0, r_out.buffer_select, r_out.out_colour,
                            r_out.screen_y, r_out.screen_x};

    // ---------------- checks ----------------
    `SBCK_ASSERT_IMP(a_skid_behind_out, r_skid_vld, r_out_vld)
    `SBCK_ASSERT_IMP(a_restore_clean, r_out_vld && (r_out.action == sbck_pkg::ACT_RESTORE),
        (r_out.out_colour == '0) && !r_out.buffer_select)
    `SBCK_ASSERT_IMP(a_out_on_screen, r_out_vld,
        (CW'(r_out.screen_x) < CW'(sbck_pkg::SCREEN_WIDTH))
        && (CW'(r_out.screen_y) < CW'(sbck_pkg::SCREEN_HEIGHT)))
    `SBCK_ASSERT_NXT(a_hit_lands, hit, r_out_vld)

endmodule
